// ===== rtl/binary_dilate_3x3_ring_unit_assert.svh =====
// assertion macros shared by the dilation unit
`ifndef BINARY_DILATE_3X3_RING_UNIT_ASSERT_SVH
`define BINARY_DILATE_3X3_RING_UNIT_ASSERT_SVH
`ifndef SYNTH
`define BDR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bdr assertion failed");
`define BDR_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("bdr forbidden condition seen");
`else
`define BDR_ASSERT(lbl, prop)
`define BDR_NEVER(lbl, expr)
`endif
`endif

// ===== rtl/bdr_pkg.sv =====
`default_nettype none
package bdr_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned OUT_RC_W  = 10;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned NRES      = 4;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QLVL_W    = $clog2(QDEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_THRESHOLD = 2'd2;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd480;
  localparam logic [PIX_W-1:0] RST_THRESHOLD    = 8'd127;
  localparam logic [PIX_W-1:0] PIX_ON           = 8'd255;
  localparam logic [PIX_W-1:0] PIX_OFF          = 8'd0;

  // window row/column selectors: oldest, middle, newest
  localparam logic [1:0] WIN_OLD = 2'd0;
  localparam logic [1:0] WIN_MID = 2'd1;
  localparam logic [1:0] WIN_NEW = 2'd2;

  // result kinds in emission order
  localparam logic [1:0] RES_BEHIND    = 2'd0;
  localparam logic [1:0] RES_ROW_END   = 2'd1;
  localparam logic [1:0] RES_LAST_ROW  = 2'd2;
  localparam logic [1:0] RES_FRAME_END = 2'd3;

  typedef struct packed {
    logic [NRES-1:0]     mask;
    logic [NRES-1:0]     vals;
    logic [OUT_RC_W-1:0] row;
    logic [OUT_RC_W-1:0] col;
  } bdr_desc_t;

  function automatic logic win_pick(input logic [8:0] win, input logic [1:0] rs,
                                    input logic [1:0] cs);
    logic [2:0] row;
    logic       b;
    case (rs)
      WIN_OLD: row = win[2:0];
      WIN_MID: row = win[5:3];
      default: row = win[8:6];
    endcase
    case (cs)
      WIN_OLD: b = row[0];
      WIN_MID: b = row[1];
      default: b = row[2];
    endcase
    return b;
  endfunction

  // or of the eight neighbours, centre (r1, c1) left out
  function automatic logic nbr_or(input logic [8:0] win,
                                  input logic [1:0] r0, input logic [1:0] r1,
                                  input logic [1:0] r2, input logic [1:0] c0,
                                  input logic [1:0] c1, input logic [1:0] c2);
    return win_pick(win, r0, c0) | win_pick(win, r0, c1) | win_pick(win, r0, c2) |
           win_pick(win, r1, c0) | win_pick(win, r1, c2) |
           win_pick(win, r2, c0) | win_pick(win, r2, c1) | win_pick(win, r2, c2);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bdr_if.sv =====
`default_nettype none
interface bdr_pix_if import bdr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface bdr_res_if import bdr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PIX_W-1:0]    out_value;
  logic [OUT_RC_W-1:0] out_row;
  logic [OUT_RC_W-1:0] out_col;
  logic                last_of_frame;

  modport source (output valid, output out_value, output out_row, output out_col,
                  output last_of_frame, input ready);
  modport sink (input valid, input out_value, input out_row, input out_col,
                input last_of_frame, output ready);
endinterface
`default_nettype wire

// ===== rtl/bdr_ram.sv =====
`default_nettype none
module bdr_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bdr_front.sv =====
`default_nettype none
`include "binary_dilate_3x3_ring_unit_assert.svh"
module bdr_front import bdr_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  bdr_pix_if.sink                     in_px,
  input  wire logic                   restart,
  input  wire logic [PIX_W-1:0]       thr,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] w_last,
  input  wire logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] h_last,
  input  wire logic [QLVL_W-1:0]      q_level,
  output logic                        push_v,
  output bdr_desc_t                   push_desc
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned FW = $clog2(MAX_WIDTH + 1);

  logic [CW-1:0]       col_r, col_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  logic [FW-1:0]       fill_r, fill_nxt;
  logic [8:0]          win_r, win_nxt, win_upd;
  logic                s1_v_r, s1_bit_r, s1_lvalid_r;
  logic [CW-1:0]       s1_col_r;
  logic [OUT_RC_W-1:0] s1_row_r;
  logic                s1_rge1_r, s1_req1_r, s1_rlast_r;
  logic                s1_cge1_r, s1_ceq1_r, s1_clast_r;
  logic                fwd_hit_r;
  logic [1:0]          fwd_data_r;
  logic [QLVL_W:0]     occ;
  logic                accept, px_bit, col_wrap;
  logic [1:0]          rd_data, line, wr_data;
  logic [1:0]          rb0, rl0, cm0, ce0;
  logic [NRES-1:0]     mask, vals;

  // room for the item in flight plus the one being taken
  assign occ         = {1'b0, q_level} + {{QLVL_W{1'b0}}, s1_v_r};
  assign in_px.ready = occ < (QLVL_W + 1)'(QDEPTH);
  assign accept      = in_px.valid && in_px.ready;
  assign px_bit      = in_px.pixel_value > thr;
  assign col_wrap    = col_r >= w_last;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = (row_r >= h_last) ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  bdr_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_col_r),
    .wdata (wr_data),
    .re    (accept),
    .raddr (col_r),
    .rdata (rd_data)
  );

  // line entry is {older row, previous row}; unwritten entries read as zero
  assign line    = fwd_hit_r ? fwd_data_r : (s1_lvalid_r ? rd_data : 2'b00);
  assign wr_data = {line[0], s1_bit_r};
  assign win_upd = {s1_bit_r, win_r[8:7], line[0], win_r[5:4], line[1], win_r[2:1]};

  always_comb begin
    win_nxt = win_r;
    if (restart) begin
      win_nxt = '0;
    end else if (s1_v_r) begin
      win_nxt = win_upd;
    end
  end

  // written entries always form a prefix of the line store
  assign fill_nxt = (s1_v_r && (FW'(s1_col_r) == fill_r)) ? fill_r + FW'(1) : fill_r;

  // edge clamping of the neighbourhood
  assign rb0 = s1_req1_r ? WIN_MID : WIN_OLD;
  assign rl0 = s1_rge1_r ? WIN_MID : WIN_NEW;
  assign cm0 = s1_ceq1_r ? WIN_MID : WIN_OLD;
  assign ce0 = s1_cge1_r ? WIN_MID : WIN_NEW;

  assign vals[RES_BEHIND]    = nbr_or(win_upd, rb0, WIN_MID, WIN_NEW, cm0, WIN_MID, WIN_NEW);
  assign vals[RES_ROW_END]   = nbr_or(win_upd, rb0, WIN_MID, WIN_NEW, ce0, WIN_NEW, WIN_NEW);
  assign vals[RES_LAST_ROW]  = nbr_or(win_upd, rl0, WIN_NEW, WIN_NEW, cm0, WIN_MID, WIN_NEW);
  assign vals[RES_FRAME_END] = nbr_or(win_upd, rl0, WIN_NEW, WIN_NEW, ce0, WIN_NEW, WIN_NEW);

  assign mask[RES_BEHIND]    = s1_rge1_r && s1_cge1_r;
  assign mask[RES_ROW_END]   = s1_rge1_r && s1_clast_r;
  assign mask[RES_LAST_ROW]  = s1_rlast_r && s1_cge1_r;
  assign mask[RES_FRAME_END] = s1_rlast_r && s1_clast_r;

  assign push_v         = s1_v_r && (mask != '0);
  assign push_desc.mask = mask;
  assign push_desc.vals = vals;
  assign push_desc.row  = s1_row_r;
  assign push_desc.col  = OUT_RC_W'(s1_col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      fill_r    <= '0;
      win_r     <= '0;
      s1_v_r    <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      fill_r    <= fill_nxt;
      win_r     <= win_nxt;
      s1_v_r    <= accept;
      fwd_hit_r <= accept && s1_v_r && (s1_col_r == col_r);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= wr_data;
    if (accept) begin
      s1_bit_r    <= px_bit;
      s1_col_r    <= col_r;
      s1_row_r    <= OUT_RC_W'(row_r);
      s1_lvalid_r <= FW'(col_r) < fill_r;
      s1_rge1_r   <= row_r != '0;
      s1_req1_r   <= row_r == RW'(1);
      s1_rlast_r  <= row_r == h_last;
      s1_cge1_r   <= col_r != '0;
      s1_ceq1_r   <= col_r == CW'(1);
      s1_clast_r  <= col_r == w_last;
    end
  end

  `BDR_ASSERT(a_push_has_room, push_v |-> q_level < QLVL_W'(QDEPTH))
  `BDR_ASSERT(a_col_in_frame, col_r <= w_last)
  `BDR_ASSERT(a_write_in_prefix, s1_v_r |-> FW'(s1_col_r) <= fill_r)

endmodule
`default_nettype wire

// ===== rtl/bdr_fifo.sv =====
`default_nettype none
module bdr_fifo import bdr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire bdr_desc_t push_data,
  input  wire logic      pop,
  output bdr_desc_t      head,
  output logic           head_v,
  output logic [QLVL_W-1:0] level
);

  localparam int unsigned PW = $clog2(QDEPTH);

  bdr_desc_t         mem_r [QDEPTH];
  logic [PW-1:0]     wp_r, rp_r;
  logic [QLVL_W-1:0] level_r, level_nxt;

  always_comb begin
    level_nxt = level_r;
    if (push && !pop) begin
      level_nxt = level_r + QLVL_W'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - QLVL_W'(1);
    end
  end

  assign head   = mem_r[rp_r];
  assign head_v = level_r != '0;
  assign level  = level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      level_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + PW'(1);
      end
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bdr_back.sv =====
`default_nettype none
`include "binary_dilate_3x3_ring_unit_assert.svh"
module bdr_back import bdr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_v,
  input  wire bdr_desc_t q_head,
  output logic           q_pop,
  bdr_res_if.source      out_res
);

  logic [NRES-1:0]     done_r, done_nxt, avail, sel_oh, rest;
  logic [1:0]          sel;
  logic                load;
  logic                out_v_r, out_v_nxt, out_last_r, last_sel;
  logic [PIX_W-1:0]    out_val_r;
  logic [OUT_RC_W-1:0] out_row_r, out_col_r, row_sel, col_sel, row_m1, col_m1;

  assign avail = q_head.mask & ~done_r;

  // lowest pending result of the head transaction goes first
  always_comb begin
    if (avail[RES_BEHIND]) begin
      sel = RES_BEHIND;
    end else if (avail[RES_ROW_END]) begin
      sel = RES_ROW_END;
    end else if (avail[RES_LAST_ROW]) begin
      sel = RES_LAST_ROW;
    end else begin
      sel = RES_FRAME_END;
    end
  end

  assign sel_oh = NRES'(1) << sel;
  assign rest   = avail & ~sel_oh;
  assign load   = q_v && (!out_v_r || out_res.ready);
  assign q_pop  = load && (rest == '0);

  assign done_nxt  = load ? (q_pop ? '0 : (done_r | sel_oh)) : done_r;
  assign out_v_nxt = load ? 1'b1 : (out_res.ready ? 1'b0 : out_v_r);

  assign row_m1 = q_head.row - OUT_RC_W'(1);
  assign col_m1 = q_head.col - OUT_RC_W'(1);

  always_comb begin
    case (sel)
      RES_BEHIND: begin
        row_sel  = row_m1;
        col_sel  = col_m1;
        last_sel = 1'b0;
      end
      RES_ROW_END: begin
        row_sel  = row_m1;
        col_sel  = q_head.col;
        last_sel = 1'b0;
      end
      RES_LAST_ROW: begin
        row_sel  = q_head.row;
        col_sel  = col_m1;
        last_sel = 1'b0;
      end
      default: begin
        row_sel  = q_head.row;
        col_sel  = q_head.col;
        last_sel = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      done_r  <= done_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_val_r  <= q_head.vals[sel] ? PIX_ON : PIX_OFF;
      out_row_r  <= row_sel;
      out_col_r  <= col_sel;
      out_last_r <= last_sel;
    end
  end

  assign out_res.valid         = out_v_r;
  assign out_res.out_value     = out_val_r;
  assign out_res.out_row       = out_row_r;
  assign out_res.out_col       = out_col_r;
  assign out_res.last_of_frame = out_last_r;

  `BDR_ASSERT(a_pop_has_work, q_pop |-> avail != '0)
  `BDR_ASSERT(a_done_idle_clear, !q_v |-> done_r == '0)
  `BDR_ASSERT(a_done_within_mask, q_v |-> (done_r & ~q_head.mask) == '0)
  `BDR_ASSERT(a_pop_restarts, q_pop |=> done_r == '0)

endmodule
`default_nettype wire

// ===== rtl/binary_dilate_3x3_ring_unit.sv =====
// 3x3 binary dilation over a raster pixel stream, edges clamped.
// in_px carries 8-bit grey pixels in raster order (valid/ready); a pixel is
// set when strictly above bright_threshold. out_res carries result pixels
// (255 when any of the eight neighbours is set, else 0) with their row,
// column and a last_of_frame flag on the final pixel of the frame.
// cfg_we/cfg_index/cfg_wdata write frame_width (0), frame_height (1) and
// bright_threshold (2); a geometry write restarts the frame at row 0, col 0.
// Results lag the source by one row and one column; the last row also emits
// its own results while it streams in, up to four results per pixel.
// A pixel's results pass through the s1 registers, the result queue and
// the output register to out_res. One pixel per cycle is taken while the
// result stream keeps up; the output register issues one result per cycle
// while out_res is ready, so the extra results at row ends and on the last
// row are absorbed by a four-entry queue and then back-pressure in_px. A
// stalled receiver fills that queue and in_px ready drops; nothing is lost.
// The line store is one 2-bit memory with one read and one write port per
// cycle. After reset the line store reads as zero through a fill count, so
// there is no clearing pass and pixels are taken as soon as reset is released.
`default_nettype none
module binary_dilate_3x3_ring_unit import bdr_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  bdr_pix_if.sink                   in_px,
  bdr_res_if.source                 out_res,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [CFG_W-1:0]  frame_width_r, frame_height_r;
  logic [PIX_W-1:0]  threshold_r;
  logic [CW-1:0]     w_last;
  logic [RW-1:0]     h_last;
  logic              restart;
  logic              push_v, q_pop, q_v;
  bdr_desc_t         push_desc, q_head;
  logic [QLVL_W-1:0] q_level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      threshold_r    <= RST_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:      frame_width_r  <= cfg_wdata;
        CFG_FRAME_HEIGHT:     frame_height_r <= cfg_wdata;
        CFG_BRIGHT_THRESHOLD: threshold_r    <= PIX_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign restart = cfg_we && (cfg_index == CFG_FRAME_WIDTH ||
                              cfg_index == CFG_FRAME_HEIGHT);

  // geometry clamped to 1..MAX, kept as last index
  assign w_last = (frame_width_r == '0) ? '0 :
                  (32'(frame_width_r) > MAX_WIDTH) ? CW'(MAX_WIDTH - 1) :
                  CW'(frame_width_r - CFG_W'(1));
  assign h_last = (frame_height_r == '0) ? '0 :
                  (32'(frame_height_r) > MAX_HEIGHT) ? RW'(MAX_HEIGHT - 1) :
                  RW'(frame_height_r - CFG_W'(1));

  bdr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_px     (in_px),
    .restart   (restart),
    .thr       (threshold_r),
    .w_last    (w_last),
    .h_last    (h_last),
    .q_level   (q_level),
    .push_v    (push_v),
    .push_desc (push_desc)
  );

  bdr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_v),
    .push_data (push_desc),
    .pop       (q_pop),
    .head      (q_head),
    .head_v    (q_v),
    .level     (q_level)
  );

  bdr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_v     (q_v),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_res (out_res)
  );

endmodule
`default_nettype wire

// ===== verif/binary_dilate_3x3_ring_unit_tb.sv =====
module binary_dilate_3x3_ring_unit_tb;
  import bdr_pkg::*;

  localparam int unsigned LINE_MAX         = 1024;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT   = 2000;
  localparam int unsigned RAND_TARGET      = 250;
  localparam int unsigned CALM_FROM        = 190;
  localparam int unsigned OVERSIZE_PIXELS  = 80;
  localparam int unsigned HOLD_MIN_PIXELS  = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0]    value;
    logic [OUT_RC_W-1:0] row;
    logic [OUT_RC_W-1:0] col;
    logic                last;
  } dil_pix_t;

  class dilation_tracker;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [PIX_W-1:0] thr_reg;
    bit               older_bits [LINE_MAX];
    bit               prev_bits [LINE_MAX];
    bit [8:0]         win;
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    dil_pix_t         owed [$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      frames_done;
    int unsigned      pixels_in;
    int unsigned      reg_writes;

    function void new_frame();
      win = '0;
      col_cnt = 0;
      row_cnt = 0;
    endfunction

    function void clear();
      foreach (older_bits[i]) begin
        older_bits[i] = 1'b0;
        prev_bits[i] = 1'b0;
      end
      width_reg = RST_FRAME_WIDTH;
      height_reg = RST_FRAME_HEIGHT;
      thr_reg = RST_THRESHOLD;
      mismatches = 0;
      checked = 0;
      frames_done = 0;
      pixels_in = 0;
      reg_writes = 0;
      owed.delete();
      new_frame();
    endfunction

    function int unsigned clamp_dim(input logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > LINE_MAX) return LINE_MAX;
      return v;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      reg_writes++;
      case (idx)
        CFG_FRAME_WIDTH: begin
          width_reg = data;
          new_frame();
        end
        CFG_FRAME_HEIGHT: begin
          height_reg = data;
          new_frame();
        end
        CFG_BRIGHT_THRESHOLD: thr_reg = data[PIX_W-1:0];
        default: ;
      endcase
    endfunction

    // or over the eight neighbours; selectors map top/mid/bottom, left/mid/right
    function bit ring_or(input bit [1:0] rt, rm, rb, cl, cm, cr);
      bit [1:0] rs [3];
      bit [1:0] cs [3];
      bit       acc;
      int       i;
      int       j;
      rs = '{rt, rm, rb};
      cs = '{cl, cm, cr};
      acc = 1'b0;
      for (i = 0; i < 3; i++)
        for (j = 0; j < 3; j++)
          if (!(i == 1 && j == 1)) acc |= win[rs[i] * 3 + cs[j]];
      return acc;
    endfunction

    function void owe(input bit lit, input int unsigned r, input int unsigned c,
                      input bit last);
      owed.push_back('{lit ? PIX_ON : PIX_OFF, OUT_RC_W'(r), OUT_RC_W'(c), last});
    endfunction

    function void take_pixel(input logic [PIX_W-1:0] pix);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      int unsigned idx;
      bit          lit;
      bit          o;
      bit          p;
      bit [1:0]    rt_b;
      bit [1:0]    rt_l;
      bit [1:0]    cl_m;
      bit [1:0]    cl_e;
      pixels_in++;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      c = col_cnt;
      r = row_cnt;
      idx = c % LINE_MAX;
      lit = pix > thr_reg;
      o = older_bits[idx];
      p = prev_bits[idx];
      // each window row shifts toward the old column, new bits enter on top
      win = {lit, win[8:7], p, win[5:4], o, win[2:1]};
      older_bits[idx] = p;
      prev_bits[idx] = lit;
      // at the frame border the missing row or column is clamped onto its neighbour
      rt_b = (r == 1) ? WIN_MID : WIN_OLD;
      rt_l = (r >= 1) ? WIN_MID : WIN_NEW;
      cl_m = (c == 1) ? WIN_MID : WIN_OLD;
      cl_e = (c >= 1) ? WIN_MID : WIN_NEW;
      if (r >= 1) begin
        if (c >= 1)
          owe(ring_or(rt_b, WIN_MID, WIN_NEW, cl_m, WIN_MID, WIN_NEW), r - 1, c - 1, 1'b0);
        if (c == w - 1)
          owe(ring_or(rt_b, WIN_MID, WIN_NEW, cl_e, WIN_NEW, WIN_NEW), r - 1, w - 1, 1'b0);
      end
      if (r == h - 1) begin
        if (c >= 1)
          owe(ring_or(rt_l, WIN_NEW, WIN_NEW, cl_m, WIN_MID, WIN_NEW), h - 1, c - 1, 1'b0);
        if (c == w - 1)
          owe(ring_or(rt_l, WIN_NEW, WIN_NEW, cl_e, WIN_NEW, WIN_NEW), h - 1, w - 1, 1'b1);
      end
      if (c >= w - 1) begin
        col_cnt = 0;
        row_cnt = (r >= h - 1) ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    function void note_bad(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_pixel(input dil_pix_t got);
      dil_pix_t want;
      if (got.last === 1'b1) frames_done++;
      if (owed.size() == 0) begin
        note_bad($sformatf("unexpected result pixel: value %0d row %0d col %0d last %0b",
                           got.value, got.row, got.col, got.last));
        return;
      end
      want = owed.pop_front();
      checked++;
      if (got.value !== want.value || got.row !== want.row || got.col !== want.col ||
          got.last !== want.last)
        note_bad($sformatf({"result pixel differs: expected value %0d row %0d col %0d ",
                            "last %0b, got value %0d row %0d col %0d last %0b"},
                           want.value, want.row, want.col, want.last,
                           got.value, got.row, got.col, got.last));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  bdr_pix_if px_if ();
  bdr_res_if res_if ();

  dilation_tracker tracker;
  bit              long_hold;
  int unsigned     sender_pct;
  int unsigned     stall_pct;
  int unsigned     quiet_cycles;

  binary_dilate_3x3_ring_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_px    (px_if),
    .out_res  (res_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && px_if.valid && px_if.ready) tracker.take_pixel(px_if.pixel_value);
  end

  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready)
      tracker.check_pixel({res_if.out_value, res_if.out_row, res_if.out_col,
                           res_if.last_of_frame});
  end

  always @(posedge clk) begin
    if (rst_n && cfg_we) tracker.write_reg(cfg_index, cfg_wdata);
  end

  always @(posedge clk) begin
    if ((px_if.valid && px_if.ready) || (res_if.valid && res_if.ready) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result receiver: random stall bursts, plus one long hold-off on request
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        res_if.ready <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] v);
    px_if.valid <= 1'b1;
    px_if.pixel_value <= v;
    do @(posedge clk); while (!px_if.ready);
  endtask

  task automatic sender_gap();
    px_if.valid <= 1'b0;
    repeat ($urandom_range(1, 13)) @(posedge clk);
  endtask

  // stop sending and wait until every owed result pixel is out
  task automatic settle();
    px_if.valid <= 1'b0;
    // wait on the clock first so the last accepted pixel is already in the tracker
    @(posedge clk);
    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return PIX_OFF;
      1: return PIX_ON;
      2: return tracker.thr_reg;
      3: return tracker.thr_reg + 1'b1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic stream_pixels(input int unsigned n);
    repeat (n) begin
      if (sender_pct != 0 && $urandom_range(0, 99) < sender_pct) sender_gap();
      send_pixel(pick_pixel());
    end
  endtask

  function automatic logic [CFG_W-1:0] pick_threshold();
    case ($urandom_range(0, 4))
      0: return {3'($urandom), PIX_OFF};
      1: return {3'($urandom), PIX_ON};
      default: return CFG_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [PIX_W-1:0] frame3 [9];
    int unsigned      phases;
    int unsigned      rand_pixels;
    int unsigned      size;
    int unsigned      n;
    frame3 = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd0, 8'd0, 8'd255, 8'd0, 8'd1};
    tracker = new;
    tracker.clear();
    long_hold = 1'b0;
    sender_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    rst_n <= 1'b0;
    px_if.valid <= 1'b0;
    px_if.pixel_value <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry is 640 wide, so these stay in row 0 and owe nothing
    send_pixel(PIX_ON);
    send_pixel(PIX_OFF);
    send_pixel(8'd128);
    send_pixel(RST_THRESHOLD);
    settle();

    // 3x3 frame: row behind, row end, last row and frame end all show up
    write_cfg(CFG_FRAME_WIDTH, 11'd3);
    write_cfg(CFG_FRAME_HEIGHT, 11'd3);
    write_cfg(CFG_UNUSED, 11'h7ff);
    foreach (frame3[i]) send_pixel(frame3[i]);
    settle();

    // zero geometry acts as 1x1, every pixel closes a frame
    write_cfg(CFG_BRIGHT_THRESHOLD, 11'd0);
    write_cfg(CFG_FRAME_WIDTH, 11'd0);
    write_cfg(CFG_FRAME_HEIGHT, 11'd1);
    send_pixel(8'd1);
    send_pixel(PIX_OFF);
    send_pixel(8'd1);
    settle();

    // nothing can exceed the top threshold
    write_cfg(CFG_BRIGHT_THRESHOLD, 11'h7ff);
    write_cfg(CFG_FRAME_WIDTH, 11'd2);
    write_cfg(CFG_FRAME_HEIGHT, 11'd2);
    send_pixel(PIX_ON);
    send_pixel(PIX_ON);
    send_pixel(PIX_ON);
    send_pixel(PIX_OFF);
    settle();

    // oversized geometry clamps to 1024: top of a one-column frame,
    // then the start of a single 1024-wide row
    sender_pct = 10;
    stall_pct = 10;
    write_cfg(CFG_BRIGHT_THRESHOLD, 11'd127);
    write_cfg(CFG_FRAME_WIDTH, 11'd0);
    write_cfg(CFG_FRAME_HEIGHT, 11'h7ff);
    stream_pixels(OVERSIZE_PIXELS);
    settle();
    write_cfg(CFG_BRIGHT_THRESHOLD, pick_threshold());
    write_cfg(CFG_FRAME_WIDTH, 11'h7ff);
    write_cfg(CFG_FRAME_HEIGHT, 11'd0);
    stream_pixels(OVERSIZE_PIXELS);
    settle();

    phases = 0;
    rand_pixels = 0;
    while (rand_pixels < RAND_TARGET) begin
      settle();
      if (rand_pixels >= CALM_FROM) begin
        sender_pct = 0;
        stall_pct = 0;
      end else begin
        sender_pct = $urandom_range(0, 1) ? 15 : 0;
        stall_pct = $urandom_range(0, 1) ? 15 : 0;
      end
      if (phases != 0 && $urandom_range(0, 3) == 0) begin
        // threshold only: the current frame carries on
        write_cfg(CFG_BRIGHT_THRESHOLD, pick_threshold());
      end else begin
        write_cfg(CFG_FRAME_WIDTH, ($urandom_range(0, 9) == 0) ?
                  CFG_W'($urandom_range(13, 40)) : CFG_W'($urandom_range(1, 10)));
        write_cfg(CFG_FRAME_HEIGHT, ($urandom_range(0, 9) == 0) ?
                  CFG_W'(0) : CFG_W'($urandom_range(1, 6)));
        if ($urandom_range(0, 5) == 0) write_cfg(CFG_UNUSED, CFG_W'($urandom));
        write_cfg(CFG_BRIGHT_THRESHOLD, pick_threshold());
      end
      size = tracker.clamp_dim(tracker.width_reg) * tracker.clamp_dim(tracker.height_reg);
      if ($urandom_range(0, 3) == 0)
        n = $urandom_range(1, size);
      else
        n = size * ((size > 60) ? 1 : $urandom_range(1, 2));
      if (phases == 0) begin
        // receiver holds off while pixels keep coming, so the input backs up
        sender_pct = 0;
        long_hold = 1'b1;
        if (n < HOLD_MIN_PIXELS) n = HOLD_MIN_PIXELS;
      end
      stream_pixels(n);
      rand_pixels += n;
      phases++;
    end
    settle();

    $display("run covered %0d pixels and %0d register writes, incl. clamped 1024 geometry",
             tracker.pixels_in, tracker.reg_writes);
    $display("checked %0d result pixels, %0d frames closed, %0d bad results",
             tracker.checked, tracker.frames_done, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.owed.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
